// File: design/elc_pkg.sv
// Shared widths, codes and helpers for the elevator LOOK controller.
`timescale 1ns / 1ps

package elc_pkg;

   // Fixed field widths
   localparam int FLOOR_W     = 4;
   localparam int FLOOR_SLOTS = 1 << FLOOR_W;   // floors an item can name
   localparam int FUNC_W      = 2;
   localparam int SRV_W       = 5;
   localparam int CAP_W       = 6;
   localparam int TRAVEL_W    = 8;
   localparam int LOAD_W      = 6;
   localparam int REQ_CNT_W   = 5;
   localparam int DIR_W       = 2;
   localparam int SPACE_W     = 6;
   localparam int SPACE_MAX   = (1 << SPACE_W) - 1;

   // Configuration port
   localparam int CSR_DATA_W  = 8;
   localparam int CSR_INDEX_W = 2;
   localparam logic [CSR_INDEX_W-1:0] CSR_FLOORS   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_CAPACITY = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_TRAVEL   = 2'd2;

   localparam logic [SRV_W-1:0]    RST_FLOORS   = 5'd16;
   localparam logic [CAP_W-1:0]    RST_CAPACITY = 6'd8;
   localparam logic [TRAVEL_W-1:0] RST_TRAVEL   = 8'd4;

   // Defaults for the top-level parameters
   localparam int DEF_MAX_FLOORS   = 16;
   localparam int DEF_MAX_CAPACITY = 63;

   typedef enum logic [DIR_W-1:0] {
      DIR_IDLE = 2'd0,
      DIR_UP   = 2'd1,
      DIR_DOWN = 2'd2
   } dir_type;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_TICK   = 2'd0,
      FUNC_ADD    = 2'd1,
      FUNC_BOARD  = 2'd2,
      FUNC_UNLOAD = 2'd3
   } func_type;

   // LOOK heading rule: reverse at the last request ahead, pick nearer end when idle
   function automatic dir_type next_heading(input dir_type cur, input logic any_req,
                                            input logic at_top, input logic at_bot,
                                            input logic up_nearer);
      dir_type nxt;
      nxt = cur;
      if (!any_req) begin
         nxt = DIR_IDLE;
      end else if (cur == DIR_UP && at_top) begin
         nxt = DIR_DOWN;
      end else if (cur == DIR_DOWN && at_bot) begin
         nxt = DIR_UP;
      end else if (cur == DIR_IDLE) begin
         nxt = up_nearer ? DIR_UP : DIR_DOWN;
      end
      return nxt;
   endfunction

endpackage

// File: design/elc_channels.sv
// Handshake channels of the elevator controller: request items and result items.
`timescale 1ns / 1ps

interface elc_req_if import elc_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [FUNC_W-1:0]  func;
   logic [FLOOR_W-1:0] floor;

   modport source (output valid, func, floor, input ready);
   modport sink   (input valid, func, floor, output ready);
endinterface

interface elc_rsp_if import elc_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [FLOOR_W-1:0]   car_floor;
   logic [DIR_W-1:0]     direction;
   logic [LOAD_W-1:0]    rider_load;
   logic [SPACE_W-1:0]   free_space;
   logic [REQ_CNT_W-1:0] request_count;
   logic [FLOOR_W-1:0]   top_request;
   logic [FLOOR_W-1:0]   bottom_request;
   logic                 accepted;
   logic [LOAD_W-1:0]    unloaded;

   modport source (output valid, car_floor, direction, rider_load, free_space,
                   request_count, top_request, bottom_request, accepted, unloaded,
                   input ready);
   modport sink   (input valid, car_floor, direction, rider_load, free_space,
                   request_count, top_request, bottom_request, accepted, unloaded,
                   output ready);
endinterface

// File: design/elc_scan.sv
// Request map scan: pending count, highest request above and lowest below the car.
`timescale 1ns / 1ps

module elc_scan import elc_pkg::*; #(
   parameter int SLOTS = FLOOR_SLOTS,
   parameter int POS_W = FLOOR_W,
   parameter int CNT_W = $clog2(SLOTS + 1)
) (
   input  logic [SLOTS-1:0] map,
   input  logic [POS_W-1:0] pos,
   input  logic [SRV_W-1:0] served,
   output logic [CNT_W-1:0] count,
   output logic [POS_W-1:0] top,
   output logic [POS_W-1:0] bottom
);

   always_comb begin
      count  = '0;
      top    = pos;
      bottom = pos;
      for (int i = 0; i < SLOTS; i++) begin
         if (map[i] && i < int'(served)) begin
            count = count + CNT_W'(1);
         end
      end
      // ascending pass: last hit is the highest
      for (int i = 0; i < SLOTS; i++) begin
         if (map[i] && i < int'(served) && i > int'(pos)) begin
            top = POS_W'(i);
         end
      end
      // descending pass: last hit is the lowest
      for (int i = SLOTS - 1; i >= 0; i--) begin
         if (map[i] && i < int'(served) && i < int'(pos)) begin
            bottom = POS_W'(i);
         end
      end
   end

endmodule

// File: design/elevator_look_controller.sv
// Top level of the single-car elevator controller with LOOK scheduling.
`timescale 1ns / 1ps

// Usage:
//   req channel carries one item per handshake: func (tick, add target, board,
//   unload here) and floor. rsp channel returns exactly one result item per
//   request item, in order: car floor, direction, load, free space, pending
//   request count, top and bottom requests, accepted flag and unloaded count.
//   csr_we/csr_index/csr_wdata write floors_in_use (0), car_capacity (1) and
//   travel_ticks (2); other indexes are ignored. Write only while no item is
//   in flight.
// Path: an accepted item passes through the input register and then the
//   result register before it is presented on rsp.
// Throughput: one item per cycle unless rsp stalls; each item is handled by
//   one pass of the request scans and heading logic between those two registers.
// Reset (synchronous, active high): car at floor 0, idle, timer 0, no
//   requests, no riders; registers return to 16, 8 and 4.
// Stall: while rsp.ready is low the result register holds; the input register
//   still takes one more item, then req.ready drops until the result moves.
module elevator_look_controller import elc_pkg::*; #(
   parameter int MAX_FLOORS   = DEF_MAX_FLOORS,
   parameter int MAX_CAPACITY = DEF_MAX_CAPACITY
) (
   input  logic                   clock,
   input  logic                   reset,
   elc_req_if.sink                req,
   elc_rsp_if.source              rsp,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   // Items name floors 0..15 only, so only those can carry requests or riders.
   localparam int SLOTS  = (MAX_FLOORS < FLOOR_SLOTS) ? MAX_FLOORS : FLOOR_SLOTS;
   localparam int SLOT_W = $clog2(SLOTS);
   localparam int POS_W  = $clog2(MAX_FLOORS);
   localparam int CNT_W  = $clog2(SLOTS + 1);

   // configuration
   logic [SRV_W-1:0]    floors_ff;
   logic [CAP_W-1:0]    capacity_ff;
   logic [TRAVEL_W-1:0] travel_ff;

   // car state
   logic [POS_W-1:0]    pos_ff, pos_in;
   dir_type             heading_ff, heading_in;
   logic [TRAVEL_W-1:0] timer_ff, timer_in;
   logic [SLOTS-1:0]    map_ff, map_in;
   logic [LOAD_W-1:0]   riders_ff [SLOTS];
   logic [LOAD_W-1:0]   riders_in [SLOTS];
   logic [LOAD_W-1:0]   load_ff, load_in;

   // input register
   logic                in_valid_ff;
   logic [FUNC_W-1:0]   in_func_ff;
   logic [FLOOR_W-1:0]  in_floor_ff;

   // result register
   logic                 out_valid_ff;
   logic [FLOOR_W-1:0]   out_floor_ff, out_floor_in;
   logic [DIR_W-1:0]     out_dir_ff, out_dir_in;
   logic [LOAD_W-1:0]    out_load_ff;
   logic [SPACE_W-1:0]   out_space_ff, out_space_in;
   logic [REQ_CNT_W-1:0] out_count_ff, out_count_in;
   logic [FLOOR_W-1:0]   out_top_ff, out_top_in;
   logic [FLOOR_W-1:0]   out_bottom_ff, out_bottom_in;
   logic                 out_acc_ff, out_acc_in;
   logic [LOAD_W-1:0]    out_unload_ff, out_unload_in;

   logic                advance;
   func_type            op;
   logic [SRV_W-1:0]    served;
   logic [CAP_W-1:0]    eff_cap;
   logic [TRAVEL_W-1:0] reload;

   logic [CNT_W-1:0]    cnt_a, cnt_b;
   logic [POS_W-1:0]    top_a, bot_a, top_b, bot_b;
   dir_type             head1;
   logic                arrive;
   logic [TRAVEL_W-1:0] timer_dec;

   logic                here_ok;
   logic [LOAD_W-1:0]   here_rd, here_new;
   logic                fl_ok, board_ok, unload_ok;
   logic signed [8:0]   space;

   assign advance   = in_valid_ff && (!out_valid_ff || rsp.ready);
   assign req.ready = !in_valid_ff || advance;
   assign op        = func_type'(in_func_ff);

   // register clamps
   always_comb begin
      if (floors_ff < SRV_W'(2)) begin
         served = SRV_W'(2);
      end else if (int'(floors_ff) > MAX_FLOORS) begin
         served = SRV_W'(MAX_FLOORS);
      end else begin
         served = floors_ff;
      end
      eff_cap = (int'(capacity_ff) > MAX_CAPACITY) ? CAP_W'(MAX_CAPACITY) : capacity_ff;
      reload  = (travel_ff < TRAVEL_W'(2)) ? TRAVEL_W'(1) : travel_ff - TRAVEL_W'(1);
   end

   // scan of the state before the item
   elc_scan #(.SLOTS(SLOTS), .POS_W(POS_W), .CNT_W(CNT_W)) u_scan_cur (
      .map    (map_ff),
      .pos    (pos_ff),
      .served (served),
      .count  (cnt_a),
      .top    (top_a),
      .bottom (bot_a)
   );

   assign head1 = next_heading(heading_ff, cnt_a != '0, pos_ff == top_a, pos_ff == bot_a,
                               (top_a - pos_ff) < (pos_ff - bot_a));

   // tick: travel timer and floor movement
   assign timer_dec = timer_ff - TRAVEL_W'(1);
   always_comb begin
      pos_in   = pos_ff;
      timer_in = timer_ff;
      arrive   = 1'b0;
      if (op == FUNC_TICK && head1 != DIR_IDLE) begin
         if (timer_ff == '0) begin
            timer_in = reload;
         end else begin
            timer_in = timer_dec;
            if (timer_dec == '0) begin
               arrive = 1'b1;
               // saturate at the building limits
               if (head1 == DIR_UP && int'(pos_ff) + 1 < int'(served)) begin
                  pos_in = pos_ff + POS_W'(1);
               end else if (head1 == DIR_DOWN && pos_ff != '0) begin
                  pos_in = pos_ff - POS_W'(1);
               end
            end
         end
      end
   end

   // riders bound for the car's floor after the item (unload keeps the floor)
   assign here_ok = int'(pos_in) < SLOTS;
   assign here_rd = here_ok ? riders_ff[pos_in[SLOT_W-1:0]] : '0;

   always_comb begin
      map_in        = map_ff;
      riders_in     = riders_ff;
      load_in       = load_ff;
      out_acc_in    = 1'b0;
      out_unload_in = '0;
      fl_ok         = int'(in_floor_ff) < int'(served);
      board_ok      = 1'b0;
      unload_ok     = 1'b0;
      case (op)
         FUNC_TICK: begin
            if (arrive && here_ok) begin
               map_in[pos_in[SLOT_W-1:0]] = 1'b0;
            end
         end
         FUNC_ADD: begin
            if (fl_ok) begin
               map_in[in_floor_ff[SLOT_W-1:0]] = 1'b1;
               out_acc_in = 1'b1;
            end
         end
         FUNC_BOARD: begin
            if (fl_ok && load_ff < eff_cap) begin
               board_ok   = 1'b1;
               riders_in[in_floor_ff[SLOT_W-1:0]] =
                  riders_ff[in_floor_ff[SLOT_W-1:0]] + LOAD_W'(1);
               load_in    = load_ff + LOAD_W'(1);
               out_acc_in = 1'b1;
            end
         end
         FUNC_UNLOAD: begin
            if (here_ok && load_ff != '0) begin
               unload_ok     = 1'b1;
               out_unload_in = (here_rd > load_ff) ? load_ff : here_rd;
               load_in       = load_ff - out_unload_in;
               riders_in[pos_in[SLOT_W-1:0]] = '0;
            end
         end
         default: begin
         end
      endcase
   end

   // scan of the state after the item
   elc_scan #(.SLOTS(SLOTS), .POS_W(POS_W), .CNT_W(CNT_W)) u_scan_next (
      .map    (map_in),
      .pos    (pos_in),
      .served (served),
      .count  (cnt_b),
      .top    (top_b),
      .bottom (bot_b)
   );

   always_comb begin
      heading_in = heading_ff;
      if (op == FUNC_TICK) begin
         heading_in = arrive ? next_heading(head1, cnt_b != '0, pos_in == top_b,
                                            pos_in == bot_b, (top_b - pos_in) < (pos_in - bot_b))
                             : head1;
      end

      if (unload_ok) begin
         here_new = '0;
      end else if (board_ok && int'(in_floor_ff) == int'(pos_in)) begin
         here_new = here_rd + LOAD_W'(1);
      end else begin
         here_new = here_rd;
      end

      // riders leaving at a stop free their space
      space = 9'(eff_cap) - 9'(load_in);
      if (timer_in == '0 && heading_in != DIR_IDLE) begin
         space = space + 9'(here_new);
      end
      if (space[8]) begin
         out_space_in = '0;
      end else if (space > 9'sd63) begin
         out_space_in = SPACE_W'(SPACE_MAX);
      end else begin
         out_space_in = space[SPACE_W-1:0];
      end

      out_floor_in  = FLOOR_W'(pos_in);
      out_dir_in    = heading_in;
      out_count_in  = REQ_CNT_W'(cnt_b);
      out_top_in    = FLOOR_W'(top_b);
      out_bottom_in = FLOOR_W'(bot_b);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         floors_ff    <= RST_FLOORS;
         capacity_ff  <= RST_CAPACITY;
         travel_ff    <= RST_TRAVEL;
         pos_ff       <= '0;
         heading_ff   <= DIR_IDLE;
         timer_ff     <= '0;
         map_ff       <= '0;
         for (int i = 0; i < SLOTS; i++) begin
            riders_ff[i] <= '0;
         end
         load_ff      <= '0;
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_FLOORS:   floors_ff   <= csr_wdata[SRV_W-1:0];
               CSR_CAPACITY: capacity_ff <= csr_wdata[CAP_W-1:0];
               CSR_TRAVEL:   travel_ff   <= csr_wdata[TRAVEL_W-1:0];
               default: begin
               end
            endcase
         end
         if (req.valid && req.ready) begin
            in_valid_ff <= 1'b1;
         end else if (advance) begin
            in_valid_ff <= 1'b0;
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
            pos_ff       <= pos_in;
            heading_ff   <= heading_in;
            timer_ff     <= timer_in;
            map_ff       <= map_in;
            riders_ff    <= riders_in;
            load_ff      <= load_in;
         end else if (rsp.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req.valid && req.ready) begin
         in_func_ff  <= req.func;
         in_floor_ff <= req.floor;
      end
      if (advance) begin
         out_floor_ff  <= out_floor_in;
         out_dir_ff    <= out_dir_in;
         out_load_ff   <= load_in;
         out_space_ff  <= out_space_in;
         out_count_ff  <= out_count_in;
         out_top_ff    <= out_top_in;
         out_bottom_ff <= out_bottom_in;
         out_acc_ff    <= out_acc_in;
         out_unload_ff <= out_unload_in;
      end
   end

   assign rsp.valid          = out_valid_ff;
   assign rsp.car_floor      = out_floor_ff;
   assign rsp.direction      = out_dir_ff;
   assign rsp.rider_load     = out_load_ff;
   assign rsp.free_space     = out_space_ff;
   assign rsp.request_count  = out_count_ff;
   assign rsp.top_request    = out_top_ff;
   assign rsp.bottom_request = out_bottom_ff;
   assign rsp.accepted       = out_acc_ff;
   assign rsp.unloaded       = out_unload_ff;

endmodule
